@@ src/mac_key_partition_selector_unit_macros.svh @@
// Assertion macros for the MAC key partition selector.
// Expect signals named clk and rst in the scope of each use.
`ifndef MAC_KEY_PARTITION_SELECTOR_UNIT_MACROS_SVH
`define MAC_KEY_PARTITION_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MKPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MKPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mkps_pkg.sv @@
// Shared types, constants and the hex decode function for the MAC key
// partition selector. No dependencies.
`default_nettype none

package mkps_pkg;

  localparam int PARTITION_BITS_DEF = 16;
  localparam int MAC_BITS           = 48;
  localparam int MASK_BITS          = 17;
  localparam int COUNT_BITS         = 5;
  localparam int STEP_BITS          = 6;

  localparam logic [COUNT_BITS-1:0] MAX_CHARS = 5'd17;
  localparam logic [COUNT_BITS-1:0] LEN_SEP   = 5'd17;
  localparam logic [COUNT_BITS-1:0] LEN_DASH  = 5'd13;
  localparam logic [COUNT_BITS-1:0] LEN_PLAIN = 5'd12;

  // Character positions of each accepted form.
  localparam logic [MASK_BITS-1:0] SEP17_MASK  = 17'h04924;
  localparam logic [MASK_BITS-1:0] HEX17_MASK  = 17'h1B6DB;
  localparam logic [MASK_BITS-1:0] HEX13_MASK  = 17'h01FBF;
  localparam logic [MASK_BITS-1:0] DASH13_MASK = 17'h00040;
  localparam logic [MASK_BITS-1:0] HEX12_MASK  = 17'h00FFF;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  typedef struct packed {
    logic [7:0] key_char;
    logic       key_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0]         partition_index;
    logic                key_valid;
    logic [MAC_BITS-1:0] mac_value;
  } out_item_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.is_hex = 1'b1;
    d.nibble = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.nibble = 4'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF) begin
      d.nibble = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      d.nibble = 4'(c - CH_UA + 8'd10);
    end else begin
      d.is_hex = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/mac_key_partition_selector_unit.sv @@
// Flow: key characters transfer one per cycle while the unit is idle; after the last
// character transfers, the result comes from 48 restoring-division steps and one load.
// A new key is not accepted until the result of the last one is loaded; the shared
// compare-subtract unit takes one address bit per cycle and sets the pace.
// Reset (rst, synchronous, active high): parse state cleared, partition
// count set to 1, no result pending.
`default_nettype none
`include "mac_key_partition_selector_unit_macros.svh"

module mac_key_partition_selector_unit
  import mkps_pkg::*;
#(
  parameter int PARTITION_BITS = PARTITION_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  localparam int ModW = (PARTITION_BITS < 16) ? PARTITION_BITS : 16;
  localparam logic [STEP_BITS-1:0] LastStep = STEP_BITS'(MAC_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic [15:0]            partition_count;
  logic [COUNT_BITS-1:0]  char_count, char_count_next;
  logic [MAC_BITS-1:0]    nibble_accumulator, nibble_accumulator_next;
  logic [MASK_BITS-1:0]   hex_position_mask, hex_position_mask_next;
  logic [MASK_BITS-1:0]   colon_position_mask, colon_position_mask_next;
  logic [MASK_BITS-1:0]   hyphen_position_mask, hyphen_position_mask_next;
  logic                   first_is_decimal, first_is_decimal_next;
  logic                   overlong_flag, overlong_flag_next;

  logic                   in_fire;
  logic                   key_ok;
  hex_digit_t             digit;
  logic [MASK_BITS-1:0]   pos_bit;

  // Division datapath
  logic [MAC_BITS-1:0]    dividend;
  logic [MAC_BITS-1:0]    mac_hold;
  logic                   valid_hold;
  logic [ModW-1:0]        modulus;
  logic [ModW-1:0]        remainder;
  logic [STEP_BITS-1:0]   step;
  logic [ModW:0]          trial;
  logic [ModW-1:0]        trial_diff;
  logic                   trial_ge;
  logic                   out_load;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign digit    = hex_decode(in_item.key_char);
  assign pos_bit  = MASK_BITS'(1) << char_count;

  always_comb begin
    char_count_next           = char_count;
    nibble_accumulator_next   = nibble_accumulator;
    hex_position_mask_next    = hex_position_mask;
    colon_position_mask_next  = colon_position_mask;
    hyphen_position_mask_next = hyphen_position_mask;
    first_is_decimal_next     = first_is_decimal;
    overlong_flag_next        = overlong_flag;
    if (char_count >= MAX_CHARS) begin
      overlong_flag_next = 1'b1;
    end else begin
      if (digit.is_hex) begin
        hex_position_mask_next  = hex_position_mask | pos_bit;
        nibble_accumulator_next = {nibble_accumulator[MAC_BITS-5:0], digit.nibble};
      end
      if (in_item.key_char == CH_COLON) begin
        colon_position_mask_next = colon_position_mask | pos_bit;
      end
      if (in_item.key_char == CH_HYPHEN) begin
        hyphen_position_mask_next = hyphen_position_mask | pos_bit;
      end
      if (char_count == '0 && in_item.key_char >= CH_ZERO &&
          in_item.key_char <= CH_NINE) begin
        first_is_decimal_next = 1'b1;
      end
      char_count_next = char_count + 1'b1;
    end
  end

  // Form check on the state as it stands after the current character
  always_comb begin
    key_ok = 1'b0;
    if (!overlong_flag_next) begin
      unique if (char_count_next == LEN_SEP) begin
        key_ok = ((hex_position_mask_next & HEX17_MASK) == HEX17_MASK) &&
                 (((colon_position_mask_next | hyphen_position_mask_next) &
                   SEP17_MASK) == SEP17_MASK);
      end else if (char_count_next == LEN_DASH) begin
        key_ok = (hex_position_mask_next == HEX13_MASK) &&
                 ((hyphen_position_mask_next & DASH13_MASK) != '0);
      end else if (char_count_next == LEN_PLAIN) begin
        key_ok = (hex_position_mask_next == HEX12_MASK) && first_is_decimal_next;
      end else begin
        key_ok = 1'b0;
      end
    end
  end

  // One restoring-division step per cycle
  assign trial      = {remainder, dividend[MAC_BITS-1]};
  assign trial_ge   = (trial >= {1'b0, modulus});
  assign trial_diff = trial[ModW-1:0] - modulus;
  assign out_load   = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_count <= 16'd1;
    end else if (cfg_wr_en) begin
      partition_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count           <= '0;
      nibble_accumulator   <= '0;
      hex_position_mask    <= '0;
      colon_position_mask  <= '0;
      hyphen_position_mask <= '0;
      first_is_decimal     <= 1'b0;
      overlong_flag        <= 1'b0;
    end else if (in_fire) begin
      if (in_item.key_last) begin
        char_count           <= '0;
        nibble_accumulator   <= '0;
        hex_position_mask    <= '0;
        colon_position_mask  <= '0;
        hyphen_position_mask <= '0;
        first_is_decimal     <= 1'b0;
        overlong_flag        <= 1'b0;
      end else begin
        char_count           <= char_count_next;
        nibble_accumulator   <= nibble_accumulator_next;
        hex_position_mask    <= hex_position_mask_next;
        colon_position_mask  <= colon_position_mask_next;
        hyphen_position_mask <= hyphen_position_mask_next;
        first_is_decimal     <= first_is_decimal_next;
        overlong_flag        <= overlong_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && in_item.key_last) begin
            state <= S_DIV;
            step  <= '0;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == LastStep) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Division payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire && in_item.key_last) begin
      mac_hold   <= key_ok ? nibble_accumulator_next : '0;
      dividend   <= key_ok ? nibble_accumulator_next : '0;
      valid_hold <= key_ok;
      modulus    <= partition_count[ModW-1:0];
      remainder  <= '0;
    end else if (state == S_DIV) begin
      dividend  <= dividend << 1;
      remainder <= trial_ge ? trial_diff : trial[ModW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.partition_index <= (modulus == '0) ? 16'd0 : 16'(remainder);
      out_item.key_valid       <= valid_hold;
      out_item.mac_value       <= mac_hold;
    end
  end

  `MKPS_ASSERT_NOW(a_rise_from_done, $rose(out_valid), $past(state == S_DONE),
                   "result without finished division")
  `MKPS_ASSERT_NOW(a_invalid_zero, out_valid && !out_item.key_valid,
                   out_item.partition_index == 16'd0 && out_item.mac_value == '0,
                   "invalid key with nonzero fields")
  `MKPS_ASSERT_NEXT(a_div_ends, state == S_DIV && step == LastStep, state == S_DONE,
                    "division did not finish on its last step")
  `MKPS_ASSERT_NEXT(a_start_div, in_fire && in_item.key_last,
                    state == S_DIV && step == '0, "last character did not start division")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the MAC key partition selector: streams key text one
// character per transfer, predicts address, validity and partition, checks each.
// Depends on mkps_pkg and mac_key_partition_selector_unit.

module testbench;
  import mkps_pkg::*;

  typedef enum logic [1:0] {ENT_CHAR, ENT_CFG, ENT_DRAIN} entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    in_item_t    item;
    logic [15:0] cfg_value;
  } key_entry_t;

  typedef logic [7:0] key_text_t[$];

  // Character positions of the accepted forms.
  localparam logic [16:0] SEP_FORM_SEPS  = 17'h04924;
  localparam logic [16:0] SEP_FORM_HEX   = 17'h1B6DB;
  localparam logic [16:0] DASH_FORM_HEX  = 17'h01FBF;
  localparam logic [16:0] DASH_FORM_DASH = 17'h00040;
  localparam logic [16:0] PLAIN_FORM_HEX = 17'h00FFF;

  localparam int SETTLE_CYCLES = 64;
  localparam int TAIL_CYCLES   = 80;
  localparam int TIMEOUT_NS    = 1_000_000;
  localparam int PHASE_CHARS   = 50;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  key_entry_t  key_chars_q[$];
  out_item_t   awaited_partitions[$];

  // Predicted parse state and partition count.
  logic [4:0]  key_len = '0;
  logic [47:0] key_acc = '0;
  logic [16:0] hex_pos = '0;
  logic [16:0] colon_pos = '0;
  logic [16:0] dash_pos = '0;
  logic        lead_decimal = 1'b0;
  logic        key_too_long = 1'b0;
  logic [15:0] part_count = 16'd1;

  int   chars_sent = 0;
  int   quiet_from = 32'h7FFF_FFFF;
  logic tail_quiet = 1'b0;
  int   mismatches = 0;
  int   send_gap = 0, send_calm = 0, settle = 0;
  int   recv_gap = 0, recv_calm = 0;

  mac_key_partition_selector_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic char_to_nibble(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      nib = c[3:0];
      return 1'b1;
    end
    if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      nib = 4'(c[2:0] + 4'd9);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic key_form_ok();
    if (key_too_long) return 1'b0;
    case (key_len)
      5'd17: return (hex_pos & SEP_FORM_HEX) == SEP_FORM_HEX &&
                    ((colon_pos | dash_pos) & SEP_FORM_SEPS) == SEP_FORM_SEPS;
      5'd13: return hex_pos == DASH_FORM_HEX && (dash_pos & DASH_FORM_DASH) != 0;
      5'd12: return hex_pos == PLAIN_FORM_HEX && lead_decimal;
      default: return 1'b0;
    endcase
  endfunction

  // Advance the predicted parse by one accepted character.
  task automatic parse_key_char(input in_item_t it);
    logic [3:0]  nib;
    logic [16:0] bit_at;
    logic        ok;
    out_item_t   r;
    if (key_len >= 5'd17) begin
      key_too_long = 1'b1;
    end else begin
      bit_at = 17'd1 << key_len;
      if (char_to_nibble(it.key_char, nib)) begin
        hex_pos |= bit_at;
        key_acc = {key_acc[43:0], nib};
      end
      if (it.key_char == CH_COLON) colon_pos |= bit_at;
      if (it.key_char == CH_HYPHEN) dash_pos |= bit_at;
      if (key_len == 0 && it.key_char >= CH_ZERO && it.key_char <= CH_NINE)
        lead_decimal = 1'b1;
      key_len = key_len + 5'd1;
    end
    if (it.key_last) begin
      ok = key_form_ok();
      r.key_valid = ok;
      r.mac_value = ok ? key_acc : 48'd0;
      r.partition_index = (ok && part_count != 0) ? 16'(key_acc % {32'd0, part_count}) : 16'd0;
      awaited_partitions.push_back(r);
      key_len = '0;
      key_acc = '0;
      hex_pos = '0;
      colon_pos = '0;
      dash_pos = '0;
      lead_decimal = 1'b0;
      key_too_long = 1'b0;
    end
  endtask

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v) - 8'd10;
  endfunction

  function automatic key_text_t make_sep_key();
    key_text_t k;
    for (int g = 0; g < 6; g++) begin
      k.push_back(rand_hex_char());
      k.push_back(rand_hex_char());
      if (g < 5) k.push_back($urandom_range(0, 1) ? CH_COLON : CH_HYPHEN);
    end
    return k;
  endfunction

  function automatic key_text_t make_dash_key();
    key_text_t k;
    for (int i = 0; i < 13; i++) k.push_back(i == 6 ? CH_HYPHEN : rand_hex_char());
    return k;
  endfunction

  function automatic key_text_t make_plain_key();
    key_text_t k;
    k.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    for (int i = 0; i < 11; i++) k.push_back(rand_hex_char());
    return k;
  endfunction

  // Damage a well-formed key in one spot.
  function automatic key_text_t break_key(input key_text_t k);
    int         pos;
    logic [7:0] junk;
    pos = $urandom_range(0, k.size() - 1);
    case ($urandom_range(0, 4))
      0: junk = 8'($urandom_range(0, 255));
      1: junk = 8'h67;                                   // 'g'
      2: junk = 8'h20;                                   // space
      3: junk = $urandom_range(0, 1) ? CH_COLON : CH_HYPHEN;
      default: junk = $urandom_range(0, 1) ? 8'h2F : 8'h60; // just outside digit/letter runs
    endcase
    case ($urandom_range(0, 4))
      0: k[pos] = junk;
      1: k.delete(pos);
      2: k.insert(pos, junk);
      3: k.insert(pos, rand_hex_char());
      default: k[0] = CH_UA + 8'($urandom_range(0, 5));
    endcase
    return k;
  endfunction

  function automatic key_text_t make_random_key();
    int        pick;
    int        len;
    key_text_t k;
    pick = $urandom_range(0, 99);
    if (pick < 22) k = make_sep_key();
    else if (pick < 40) k = make_dash_key();
    else if (pick < 58) k = make_plain_key();
    else if (pick < 80) begin
      case ($urandom_range(0, 2))
        0: k = break_key(make_sep_key());
        1: k = break_key(make_dash_key());
        default: k = break_key(make_plain_key());
      endcase
    end else if (pick < 90) begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++)
        k.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : rand_hex_char());
    end else begin
      k = make_sep_key();
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) k.push_back(rand_hex_char());
    end
    return k;
  endfunction

  task automatic queue_key(input key_text_t k);
    key_entry_t e;
    foreach (k[i]) begin
      e.kind = ENT_CHAR;
      e.item.key_char = k[i];
      e.item.key_last = (i == k.size() - 1);
      e.cfg_value = 16'd0;
      key_chars_q.push_back(e);
    end
  endtask

  task automatic queue_text(input string s);
    key_text_t k;
    for (int i = 0; i < s.len(); i++) k.push_back(s[i]);
    queue_key(k);
  endtask

  task automatic queue_marker(input entry_kind_e kind, input logic [15:0] value);
    key_entry_t e;
    e.kind = kind;
    e.item = '0;
    e.cfg_value = value;
    key_chars_q.push_back(e);
  endtask

  // Driver: feed characters, hold on stall, write the register only when drained.
  always @(posedge clk) begin : drive
    logic        nv;
    in_item_t    ni;
    logic        ncfg;
    logic [15:0] ndata;
    key_entry_t  head;
    nv = in_valid;
    ni = in_item;
    ncfg = 1'b0;
    ndata = cfg_wr_data;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_key_char(in_item);
        chars_sent++;
        nv = 1'b0;
      end
      if (!nv && key_chars_q.size() != 0) begin
        head = key_chars_q[0];
        if (head.kind == ENT_CHAR) begin
          if (!tail_quiet && send_gap == 0 && send_calm == 0) begin
            send_gap = $urandom_range(1, 18);
            send_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 250)
                                                    : $urandom_range(0, 25);
          end
          if (!tail_quiet && send_gap > 0) begin
            send_gap--;
          end else begin
            if (send_calm > 0) send_calm--;
            nv = 1'b1;
            ni = head.item;
            key_chars_q.delete(0);
          end
        end else if (awaited_partitions.size() != 0) begin
          settle = 0;
        end else if (settle < SETTLE_CYCLES) begin
          settle++;
        end else begin
          settle = 0;
          if (head.kind == ENT_CFG) begin
            ncfg = 1'b1;
            ndata = head.cfg_value;
            part_count = head.cfg_value;
          end
          key_chars_q.delete(0);
        end
      end
    end
    in_valid <= nv;
    in_item <= ni;
    cfg_wr_en <= ncfg;
    cfg_wr_data <= ndata;
    tail_quiet <= (chars_sent >= quiet_from);
  end

  // Monitor: check each result transfer against the oldest prediction; drive random stalls.
  always @(posedge clk) begin : observe
    out_item_t want;
    logic      nstall;
    nstall = out_stall;
    if (rst) begin
      nstall = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_partitions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result idx=%0d valid=%0b mac=%012h", $realtime,
                     out_item.partition_index, out_item.key_valid, out_item.mac_value);
        end else begin
          want = awaited_partitions.pop_front();
          if (out_item.partition_index !== want.partition_index ||
              out_item.key_valid !== want.key_valid ||
              out_item.mac_value !== want.mac_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected idx=%0d valid=%0b mac=%012h,", $realtime,
                       want.partition_index, want.key_valid, want.mac_value,
                       " got idx=%0d valid=%0b mac=%012h",
                       out_item.partition_index, out_item.key_valid, out_item.mac_value);
          end
        end
      end
      if (tail_quiet) begin
        nstall = 1'b0;
      end else begin
        if (recv_gap == 0 && recv_calm == 0) begin
          recv_gap = $urandom_range(1, 18);
          recv_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 250)
                                                  : $urandom_range(0, 25);
        end
        if (recv_gap > 0) begin
          recv_gap--;
          nstall = 1'b1;
        end else begin
          if (recv_calm > 0) recv_calm--;
          nstall = 1'b0;
        end
      end
    end
    out_stall <= nstall;
  end

  initial begin : stimulus
    logic [15:0] phase_counts[10];
    int          phase_chars;
    key_text_t   k;
    phase_counts = '{16'd2, 16'd3, 16'd255, 16'd256, 16'd65534,
                     16'd1, 16'd0, 16'd7, 16'd65535, 16'd0};
    phase_counts[6] = 16'($urandom_range(1, 65535));
    phase_counts[9] = 16'($urandom_range(1, 65535));

    // Directed keys at the reset partition count, then at the extremes.
    queue_text("00:00:00:00:00:00");
    queue_text("ff-FF:aa-AA:09-90");
    queue_marker(ENT_CFG, 16'd65535);
    queue_text("FF:FF:FF:FF:FF:FF");
    queue_text("abcdef-ABCDEF");
    queue_text("9fFfFfFfFfFf");
    queue_text("a12345678901");
    queue_text("0x1234567890");
    queue_text("12:34:56:78:9A:BC:D");
    queue_text("-");
    queue_marker(ENT_CFG, 16'd0);
    queue_text("12-34-56-78-9a-bc");
    queue_text("123456:789abc");

    foreach (phase_counts[p]) begin
      queue_marker(ENT_CFG, phase_counts[p]);
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        k = make_random_key();
        queue_key(k);
        phase_chars += k.size();
        // Let everything drain once, after the first key of phase 4.
        if (p == 4 && phase_chars == k.size()) queue_marker(ENT_DRAIN, 16'd0);
      end
    end
    phase_chars = 0;
    foreach (key_chars_q[i]) if (key_chars_q[i].kind == ENT_CHAR) phase_chars++;
    quiet_from = phase_chars - 100;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (key_chars_q.size() != 0 || in_valid || awaited_partitions.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/mkps_pkg.sv
src/mac_key_partition_selector_unit.sv
test/testbench.sv
